>>> hw/rtl/websocket_frame_header_decoder_core_defines.svh
// Assertion macros shared by the frame header decoder RTL.
`ifndef WEBSOCKET_FRAME_HEADER_DECODER_CORE_DEFINES_SVH
`define WEBSOCKET_FRAME_HEADER_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define WSFHD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define WSFHD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/wsfhd_pkg.sv
// Types and constants of the WebSocket frame header decoder.
package wsfhd_pkg;

    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 120;
    localparam int unsigned M_FIELDS_W = 113;

    // Length codes that announce an extended length
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    // Byte counts of the extended length and the key; eight wraps the 3-bit index to zero
    localparam logic [2:0] EXT16_BYTES = 3'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [2:0] KEY_BYTES   = 3'd4;

    typedef enum logic [2:0] {
        PH_FIRST,
        PH_SECOND,
        PH_EXT,
        PH_KEY,
        PH_PAYLOAD
    } t_phase;

    typedef struct packed {
        logic [3:0]  header_length;
        logic [31:0] mask_key;
        logic [63:0] payload_length;
        logic        masked;
        logic [7:0]  flag_bits;
        logic [3:0]  opcode;
    } t_result;

endpackage

>>> hw/rtl/wsfhd_parser.sv
// Header parse state, per-word field capture and result formation.
module wsfhd_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic [7:0]          i_byte,
    input  logic                i_last,
    output wsfhd_pkg::t_result  o_result
);

    wsfhd_pkg::t_phase r_phase, n_phase;
    logic [2:0]  r_idx, n_idx;
    logic [7:0]  r_first_byte, n_first_byte;
    logic        r_mask_bit, n_mask_bit;
    logic [63:0] r_length, n_length;
    logic [63:0] r_ext_acc, n_ext_acc;
    logic [31:0] r_key_stage, n_key_stage;
    logic [31:0] r_key, n_key;
    logic [3:0]  r_hdr_count, n_hdr_count;
    logic [63:0] r_payload_count, n_payload_count;

    logic [2:0]  w_idx_inc;
    logic [2:0]  w_ext_need;
    logic        w_ext_code;
    logic        w_ext_done;
    logic        w_key_done;
    logic [63:0] w_ext_shift;
    logic [31:0] w_key_shift;

    assign w_idx_inc   = r_idx + 3'd1;
    assign w_ext_need  = (r_length[6:0] == wsfhd_pkg::LEN_EXT16) ? wsfhd_pkg::EXT16_BYTES
                                                                  : wsfhd_pkg::EXT64_BYTES[2:0];
    assign w_ext_code  = (i_byte[6:0] == wsfhd_pkg::LEN_EXT16) ||
                         (i_byte[6:0] == wsfhd_pkg::LEN_EXT64);
    assign w_ext_done  = (w_idx_inc == w_ext_need);
    assign w_key_done  = (w_idx_inc == wsfhd_pkg::KEY_BYTES);
    assign w_ext_shift = {r_ext_acc[55:0], i_byte};
    assign w_key_shift = {r_key_stage[23:0], i_byte};

    // Next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            wsfhd_pkg::PH_FIRST: begin
                n_phase = wsfhd_pkg::PH_SECOND;
            end
            wsfhd_pkg::PH_SECOND: begin
                if (w_ext_code) begin
                    n_phase = wsfhd_pkg::PH_EXT;
                end else if (i_byte[7]) begin
                    n_phase = wsfhd_pkg::PH_KEY;
                end else begin
                    n_phase = wsfhd_pkg::PH_PAYLOAD;
                end
            end
            wsfhd_pkg::PH_EXT: begin
                if (w_ext_done) begin
                    n_phase = r_mask_bit ? wsfhd_pkg::PH_KEY : wsfhd_pkg::PH_PAYLOAD;
                end
            end
            wsfhd_pkg::PH_KEY: begin
                if (w_key_done) begin
                    n_phase = wsfhd_pkg::PH_PAYLOAD;
                end
            end
            wsfhd_pkg::PH_PAYLOAD: begin
                n_phase = wsfhd_pkg::PH_PAYLOAD;
            end
            default: begin
                n_phase = wsfhd_pkg::PH_FIRST;
            end
        endcase
    end

    // Field capture for the current word
    always_comb begin
        n_idx           = r_idx;
        n_first_byte    = r_first_byte;
        n_mask_bit      = r_mask_bit;
        n_length        = r_length;
        n_ext_acc       = r_ext_acc;
        n_key_stage     = r_key_stage;
        n_key           = r_key;
        n_hdr_count     = r_hdr_count;
        n_payload_count = r_payload_count;
        unique case (r_phase)
            wsfhd_pkg::PH_FIRST: begin
                n_first_byte = i_byte;
                n_hdr_count  = r_hdr_count + 4'd1;
            end
            wsfhd_pkg::PH_SECOND: begin
                n_mask_bit  = i_byte[7];
                n_length    = {57'd0, i_byte[6:0]};
                n_hdr_count = r_hdr_count + 4'd1;
                n_ext_acc   = '0;
                n_idx       = '0;
            end
            wsfhd_pkg::PH_EXT: begin
                n_ext_acc   = w_ext_shift;
                n_hdr_count = r_hdr_count + 4'd1;
                n_idx       = w_idx_inc;
                if (w_ext_done) begin
                    n_length = w_ext_shift;
                    n_idx    = '0;
                end
            end
            wsfhd_pkg::PH_KEY: begin
                n_key_stage = w_key_shift;
                n_hdr_count = r_hdr_count + 4'd1;
                n_idx       = w_idx_inc;
                if (w_key_done) begin
                    n_key = w_key_shift;
                    n_idx = '0;
                end
            end
            default: begin
                // saturate at all ones
                if (!(&r_payload_count)) begin
                    n_payload_count = r_payload_count + 64'd1;
                end
            end
        endcase
    end

    // Result seen after this word; a lone first byte yields all zeros
    always_comb begin
        o_result = '0;
        if (n_phase != wsfhd_pkg::PH_SECOND) begin
            o_result.opcode         = n_first_byte[3:0];
            o_result.flag_bits      = {n_first_byte[7:4], 4'd0};
            o_result.masked         = n_mask_bit;
            o_result.payload_length = n_length;
            o_result.mask_key       = n_key;
            if ((n_phase == wsfhd_pkg::PH_PAYLOAD) && (n_payload_count >= n_length)) begin
                o_result.header_length = n_hdr_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_last)) begin
            r_phase         <= wsfhd_pkg::PH_FIRST;
            r_idx           <= '0;
            r_first_byte    <= '0;
            r_mask_bit      <= 1'b0;
            r_length        <= '0;
            r_ext_acc       <= '0;
            r_key_stage     <= '0;
            r_key           <= '0;
            r_hdr_count     <= '0;
            r_payload_count <= '0;
        end else if (i_fire) begin
            r_phase         <= n_phase;
            r_idx           <= n_idx;
            r_first_byte    <= n_first_byte;
            r_mask_bit      <= n_mask_bit;
            r_length        <= n_length;
            r_ext_acc       <= n_ext_acc;
            r_key_stage     <= n_key_stage;
            r_key           <= n_key;
            r_hdr_count     <= n_hdr_count;
            r_payload_count <= n_payload_count;
        end
    end

endmodule

>>> hw/rtl/websocket_frame_header_decoder_core.sv
// WebSocket frame header decoder: top level with input and result registers.
//
// Input stream: one buffer byte per word on i_s_tdata, i_s_tlast on the final byte.
// Output stream: one word per buffer, sent after its final byte, carrying opcode,
// flag nibble, mask bit, payload length, masking key and header length.
// Order: a byte taken into the input register is parsed from there, and the result
// word is loaded into the result register when the parser takes the final byte.
// Throughput: one byte per cycle; only a final byte needs a free result register,
// and it stalls until one is free. The single header parser steps once per byte.
// While a result word waits for i_m_tready, non-final bytes keep flowing; a final
// byte holds in the input register, with o_s_tready low, until the result register
// frees up.
// Reset (i_rst_n low, synchronous) empties both registers and returns the parser
// to expect the first byte of a frame; after each final byte the parser returns to
// that state on its own.
`include "websocket_frame_header_decoder_core_defines.svh"

module websocket_frame_header_decoder_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [wsfhd_pkg::S_TDATA_W-1:0]    i_s_tdata,   // [7:0] data_byte
    input  logic                               i_s_tlast,   // last_byte
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [3:0] opcode, [11:4] flag_bits, [12] masked, [76:13] payload_length,
    // [108:77] mask_key, [112:109] header_length, [119:113] zero
    output logic [wsfhd_pkg::M_TDATA_W-1:0]    o_m_tdata
);

    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    logic                r_in_last;
    logic                r_out_valid;
    wsfhd_pkg::t_result  r_out;
    wsfhd_pkg::t_result  w_result;
    logic                w_out_free;
    logic                w_fire;

    assign w_out_free = !r_out_valid || i_m_tready;
    // a non-final word never needs the result register
    assign w_fire     = r_in_valid && (!r_in_last || w_out_free);
    assign o_s_tready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata[7:0];
            r_in_last <= i_s_tlast;
        end
    end

    wsfhd_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && r_in_last) begin
            r_out <= w_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(wsfhd_pkg::M_TDATA_W - wsfhd_pkg::M_FIELDS_W){1'b0}}, r_out};

    `WSFHD_ASSERT_NEXT(a_last_makes_result, w_fire && r_in_last, r_out_valid, "final word lost its result")
    `WSFHD_ASSERT_NEXT(a_in_word_held, r_in_valid && !w_fire, r_in_valid, "stalled input word dropped")
    `WSFHD_ASSERT_NOW(a_key_needs_mask, r_out_valid && (r_out.mask_key != 32'd0), r_out.masked, "key without mask bit")

endmodule

>>> dv/tb_websocket_frame_header_decoder_core.sv
`timescale 1ns / 1ps
// Testbench of the WebSocket frame header decoder core: byte stream in, decoded headers checked.
module tb_websocket_frame_header_decoder_core;

    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } t_word;

    localparam int CYCLE_LIMIT = 200000;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic [7:0]                      s_tdata = 8'h00;
    logic                            s_tlast = 1'b0;
    logic                            m_tready = 1'b0;
    logic                            o_s_tready;
    logic                            o_m_tvalid;
    logic [wsfhd_pkg::M_TDATA_W-1:0] o_m_tdata;

    // header parser shadow
    wsfhd_pkg::t_phase hdr_phase;
    logic [2:0]  hdr_idx;
    logic [7:0]  hdr_first;
    logic        hdr_mask;
    logic [63:0] hdr_len;
    logic [63:0] ext_len_acc;
    logic [31:0] mask_key_acc;
    logic [31:0] mask_key_val;
    logic [3:0]  hdr_bytes;
    logic [63:0] payload_seen;

    t_word              pending_words[$];
    wsfhd_pkg::t_result expected_headers[$];

    int cycle_cnt = 0;
    int words_queued = 0;
    int buffers_queued = 0;
    int words_sent = 0;
    int headers_seen = 0;
    int mismatches = 0;
    int long_holds = 0;
    int gap_left = 0;
    int stall_left = 0;

    // one stretch in four runs with no idling on either side
    wire calm = ((cycle_cnt >> 9) % 4) == 1;

    websocket_frame_header_decoder_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),      // [7:0] data_byte
        .i_s_tlast  (s_tlast),      // last_byte
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        // [3:0] opcode, [11:4] flag_bits, [12] masked, [76:13] payload_length,
        // [108:77] mask_key, [112:109] header_length, [119:113] zero
        .o_m_tdata  (o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    task automatic parser_clear();
        hdr_phase    = wsfhd_pkg::PH_FIRST;
        hdr_idx      = '0;
        hdr_first    = '0;
        hdr_mask     = 1'b0;
        hdr_len      = '0;
        ext_len_acc  = '0;
        mask_key_acc = '0;
        mask_key_val = '0;
        hdr_bytes    = '0;
        payload_seen = '0;
    endtask

    task automatic parse_byte(input t_word w);
        wsfhd_pkg::t_result hdr;
        case (hdr_phase)
            wsfhd_pkg::PH_FIRST: begin
                hdr_first = w.data;
                hdr_bytes++;
                hdr_phase = wsfhd_pkg::PH_SECOND;
            end
            wsfhd_pkg::PH_SECOND: begin
                hdr_mask = w.data[7];
                hdr_len = {57'd0, w.data[6:0]};
                hdr_bytes++;
                ext_len_acc = '0;
                hdr_idx = '0;
                if (w.data[6:0] == wsfhd_pkg::LEN_EXT16 ||
                    w.data[6:0] == wsfhd_pkg::LEN_EXT64) begin
                    hdr_phase = wsfhd_pkg::PH_EXT;
                end else begin
                    hdr_phase = hdr_mask ? wsfhd_pkg::PH_KEY : wsfhd_pkg::PH_PAYLOAD;
                end
            end
            wsfhd_pkg::PH_EXT: begin
                ext_len_acc = {ext_len_acc[55:0], w.data};
                hdr_bytes++;
                hdr_idx++;
                // the eight-byte count wraps the index back to zero
                if (hdr_idx == ((hdr_len[6:0] == wsfhd_pkg::LEN_EXT16) ?
                                wsfhd_pkg::EXT16_BYTES : wsfhd_pkg::EXT64_BYTES[2:0]))
                begin
                    hdr_len = ext_len_acc;
                    hdr_idx = '0;
                    hdr_phase = hdr_mask ? wsfhd_pkg::PH_KEY : wsfhd_pkg::PH_PAYLOAD;
                end
            end
            wsfhd_pkg::PH_KEY: begin
                mask_key_acc = {mask_key_acc[23:0], w.data};
                hdr_bytes++;
                hdr_idx++;
                if (hdr_idx == wsfhd_pkg::KEY_BYTES) begin
                    mask_key_val = mask_key_acc;
                    hdr_idx = '0;
                    hdr_phase = wsfhd_pkg::PH_PAYLOAD;
                end
            end
            default: begin
                if (payload_seen != '1) payload_seen++;
            end
        endcase
        if (w.last) begin
            hdr = '0;
            // a one-byte buffer decodes to all zeros
            if (hdr_phase != wsfhd_pkg::PH_SECOND) begin
                hdr.opcode         = hdr_first[3:0];
                hdr.flag_bits      = {hdr_first[7:4], 4'h0};
                hdr.masked         = hdr_mask;
                hdr.payload_length = hdr_len;
                hdr.mask_key       = mask_key_val;
                if (hdr_phase == wsfhd_pkg::PH_PAYLOAD && payload_seen >= hdr_len) begin
                    hdr.header_length = hdr_bytes;
                end
            end
            expected_headers.push_back(hdr);
            parser_clear();
        end
    endtask

    // Queue one buffer: header built from the arguments, random payload, cut short if asked.
    task automatic add_buffer(input logic [7:0] b0, input logic [7:0] b1, input logic [63:0] ext,
                              input logic [31:0] mkey, input int n_payload, input int cut);
        logic [7:0] bytes_q[$];
        t_word      w;
        int         n;
        bytes_q.push_back(b0);
        bytes_q.push_back(b1);
        if (b1[6:0] == wsfhd_pkg::LEN_EXT16) begin
            bytes_q.push_back(ext[15:8]);
            bytes_q.push_back(ext[7:0]);
        end else if (b1[6:0] == wsfhd_pkg::LEN_EXT64) begin
            for (int i = 7; i >= 0; i--) bytes_q.push_back(ext[i*8 +: 8]);
        end
        if (b1[7]) begin
            for (int i = 3; i >= 0; i--) bytes_q.push_back(mkey[i*8 +: 8]);
        end
        repeat (n_payload) bytes_q.push_back(8'($urandom));
        n = bytes_q.size();
        if (cut > 0 && cut < n) n = cut;
        for (int i = 0; i < n; i++) begin
            w.data = bytes_q[i];
            w.last = (i == n - 1);
            pending_words.push_back(w);
        end
        words_queued += n;
        buffers_queued++;
    endtask

    function automatic int idle_len();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("header %0d: %s expected 0x%0h, got 0x%0h", headers_seen, what, want, got);
        end
    endtask

    // driver
    always @(posedge i_clk) begin : drv
        t_word w;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_tvalid && o_s_tready) begin
                parse_byte({s_tlast, s_tdata});
                words_sent++;
            end
            if (!s_tvalid || o_s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    w = pending_words.pop_front();
                    s_tdata  <= w.data;
                    s_tlast  <= w.last;
                    s_tvalid <= 1'b1;
                    gap_left = idle_len();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : mon
        wsfhd_pkg::t_result got;
        wsfhd_pkg::t_result want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_m_tvalid && m_tready) begin
                headers_seen++;
                got = o_m_tdata[wsfhd_pkg::M_FIELDS_W-1:0];
                if (o_m_tdata[wsfhd_pkg::M_TDATA_W-1:wsfhd_pkg::M_FIELDS_W] !== '0) begin
                    note_mismatch("padding", 64'd0,
                                  64'(o_m_tdata[wsfhd_pkg::M_TDATA_W-1:wsfhd_pkg::M_FIELDS_W]));
                end
                if (expected_headers.size() == 0) begin
                    note_mismatch("unrequested word, payload_length", 64'd0, got.payload_length);
                end else begin
                    want = expected_headers.pop_front();
                    if (got.opcode !== want.opcode)
                        note_mismatch("opcode", 64'(want.opcode), 64'(got.opcode));
                    if (got.flag_bits !== want.flag_bits)
                        note_mismatch("flag_bits", 64'(want.flag_bits), 64'(got.flag_bits));
                    if (got.masked !== want.masked)
                        note_mismatch("masked", 64'(want.masked), 64'(got.masked));
                    if (got.payload_length !== want.payload_length)
                        note_mismatch("payload_length", want.payload_length, got.payload_length);
                    if (got.mask_key !== want.mask_key)
                        note_mismatch("mask_key", 64'(want.mask_key), 64'(got.mask_key));
                    if (got.header_length !== want.header_length)
                        note_mismatch("header_length", 64'(want.header_length),
                                      64'(got.header_length));
                end
                // hold off long enough for final bytes to back up into the input
                if (headers_seen == 10 || headers_seen == 30) begin
                    stall_left = $urandom_range(150, 250);
                    long_holds++;
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left = idle_len();
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d headers outstanding",
                     cycle_cnt, expected_headers.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin : stim
        int          kind;
        int          sel;
        int          hsize;
        int          npay;
        int          cut;
        logic        mbit;
        logic        wide_len;
        logic [6:0]  code;
        logic [63:0] ext;
        parser_clear();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // one-byte buffer
        add_buffer(8'hFF, 8'h00, 64'd0, 32'd0, 0, 1);
        // minimal complete header, empty payload
        add_buffer(8'h81, 8'h00, 64'd0, 32'd0, 0, 0);
        // 16-bit extended length cut off
        add_buffer(8'h0A, {1'b0, wsfhd_pkg::LEN_EXT16}, 64'h1234, 32'd0, 0, 3);
        // 64-bit extended length cut off, mask set
        add_buffer(8'hF0, {1'b1, wsfhd_pkg::LEN_EXT64}, 64'd0, 32'd0, 0, 5);
        // masked, whole payload
        add_buffer(8'h82, 8'h81, 64'd0, 32'hFFFF_FFFF, 1, 0);
        // masking key cut off
        add_buffer(8'h88, 8'h83, 64'd0, 32'hAA55_00FF, 3, 4);
        // payload shorter than its length
        add_buffer(8'h8F, 8'h05, 64'd0, 32'd0, 2, 0);

        // sender waits for every header before going on
        do @(negedge i_clk);
        while (pending_words.size() != 0 || s_tvalid || expected_headers.size() != 0);

        while (words_queued < 450 || buffers_queued < 40) begin
            kind = $urandom_range(0, 99);
            sel = $urandom_range(0, 19);
            mbit = 1'($urandom);
            wide_len = ($urandom_range(0, 3) == 0);
            if (sel < 12) begin
                code = 7'($urandom_range(0, 15));
                ext = 64'(code);
            end else if (sel == 12) begin
                code = 7'($urandom_range(100, 125));
                ext = 64'(code);
            end else if (sel < 16) begin
                code = wsfhd_pkg::LEN_EXT16;
                ext = wide_len ? 64'($urandom_range(0, 16'hFFFF)) : 64'($urandom_range(0, 24));
            end else begin
                code = wsfhd_pkg::LEN_EXT64;
                ext = wide_len ? {$urandom, $urandom} : 64'($urandom_range(0, 24));
            end
            if (ext > 64'd40) begin
                npay = $urandom_range(0, 6);
            end else begin
                npay = int'(ext) + int'($urandom_range(0, 4)) - 2;
                if (npay < 0) npay = 0;
            end
            hsize = 2 + (mbit ? int'(wsfhd_pkg::KEY_BYTES) : 0);
            if (code == wsfhd_pkg::LEN_EXT16) hsize += int'(wsfhd_pkg::EXT16_BYTES);
            if (code == wsfhd_pkg::LEN_EXT64) hsize += int'(wsfhd_pkg::EXT64_BYTES);
            if (kind < 80) begin
                add_buffer(8'($urandom), {mbit, code}, ext, $urandom, npay, 0);
            end else if (kind < 92) begin
                cut = $urandom_range(1, hsize);
                add_buffer(8'($urandom), {mbit, code}, ext, $urandom, npay, cut);
            end else begin
                // noise: random header bytes chopped at a random point
                add_buffer(8'($urandom), 8'($urandom), {$urandom, $urandom}, $urandom,
                           $urandom_range(0, 3), $urandom_range(1, 6));
            end
        end

        do @(negedge i_clk);
        while (pending_words.size() != 0 || s_tvalid || expected_headers.size() != 0);
        repeat (8) @(negedge i_clk);

        $display("sent %0d bytes in %0d buffers, checked %0d decoded headers",
                 words_sent, buffers_queued, headers_seen);
        $display("%0d long output holds, %0d mismatching fields", long_holds, mismatches);
        if (mismatches == 0 && expected_headers.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
